// File: rtl/core/scsc_pkg.sv
// Shared constants, codes and types of the shadow call stack checker.
package scsc_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;

   localparam int XLEN        = 32;
   localparam int ENTRY_W     = 2 * XLEN;
   localparam int STATUS_W    = 3;
   localparam int DEPTH_OUT_W = 7;
   localparam int CSR_IDX_W   = 2;

   localparam int REQ_DATA_W  = 4 * XLEN;
   localparam int RSP_FIELD_W = STATUS_W + 2 * XLEN + DEPTH_OUT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [XLEN-1:0] RET_WORD      = 32'h0000_8067;
   localparam logic [XLEN-1:0] ECALL_RESET   = 32'h0000_0073;
   localparam logic [6:0]      OPC_JAL       = 7'h6F;
   localparam logic [6:0]      OPC_JALR      = 7'h67;
   localparam logic [4:0]      RA_REG        = 5'd1;
   localparam logic [XLEN-1:0] RET_ADDR_STEP = 32'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIBRARY_END = 2'd0,
      CSR_ECALL_WORD  = 2'd1,
      CSR_START_PC    = 2'd2,
      CSR_INITIAL_SP  = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NONE        = 3'd0,
      STAT_PUSHED      = 3'd1,
      STAT_POPPED      = 3'd2,
      STAT_UNDERFLOW   = 3'd3,
      STAT_RA_MISMATCH = 3'd4,
      STAT_SP_MISMATCH = 3'd5,
      STAT_OVERFLOW    = 3'd6
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic is_pop;
      logic is_call;
   } decode_type;

endpackage

// File: rtl/core/scsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scsc_ram
   import scsc_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/scsc_decode.sv
// Instruction classification: effective word, return/ecall pop and call push.
module scsc_decode
   import scsc_pkg::*;
(
   input  logic [XLEN-1:0] pc,
   input  logic [XLEN-1:0] instr_word,
   input  logic [XLEN-1:0] library_end,
   input  logic [XLEN-1:0] ecall_word,
   output logic [XLEN-1:0] effective_word,
   output decode_type      dec
);

   logic [6:0] opcode;
   logic       link_ra;

   always_comb begin
      effective_word = (pc < library_end) ? ecall_word : instr_word;
      opcode         = effective_word[6:0];
      link_ra        = (effective_word[11:7] == RA_REG)
                       && ((opcode == OPC_JAL) || (opcode == OPC_JALR));
      dec.is_pop     = (effective_word == RET_WORD) || (effective_word == ecall_word);
      dec.is_call    = link_ra && !dec.is_pop;
   end

endmodule

// File: rtl/core/shadow_call_stack_checker.sv
// Top level of the shadow call stack checker: registers, control and result stage.
//
//   channel | dir | transfer when          | contents
//   --------+-----+------------------------+---------------------------------------
//   req_    | in  | req_tvalid & req_tready | pc, instr_word, ra_value, sp_value
//   rsp_    | out | rsp_tvalid & rsp_tready | status, effective_word, expected, depth
//   csr_    | in  | csr_we                  | index 0..3, 32-bit data
//
// S_IDLE accepts an item and reads the top entry from the stack RAM, and S_EXEC checks it,
// writes back a push and loads the result register; req_tready is low during S_EXEC.
// S_EXEC holds while the result register is full and rsp_tready is low.
// Reset is synchronous: one entry held (the bottom pair), configuration at reset values;
// the stack RAM is not cleared, as only written entries are ever read.
module shadow_call_stack_checker
   import scsc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] pc, [63:32] instr_word, [95:64] ra_value, [127:96] sp_value
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] status, [34:3] effective_word, [66:35] expected_value, [73:67] stack_depth
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [XLEN-1:0]       csr_wdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 2);

   state_type state_ff, state_in;

   logic [XLEN-1:0] lib_end_ff, ecall_word_ff, bottom_pc_ff, bottom_sp_ff;
   logic [CW-1:0]   count_ff, count_in;

   logic [XLEN-1:0] pc_ff, ra_ff, sp_ff, eff_word_ff;
   decode_type      dec_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff, status_in;
   logic [XLEN-1:0]        rsp_word_ff;
   logic [XLEN-1:0]        rsp_expected_ff, expected_in;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff;

   logic [XLEN-1:0] req_pc, req_word, req_ra, req_sp, dec_word;
   decode_type      dec_in;

   logic            accept, finish;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_rd_addr, ram_wr_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [XLEN-1:0] top_pc, top_sp, ra_expect;
   logic            push_bottom;

   assign req_pc   = req_tdata[XLEN-1:0];
   assign req_word = req_tdata[2*XLEN-1:XLEN];
   assign req_ra   = req_tdata[3*XLEN-1:2*XLEN];
   assign req_sp   = req_tdata[4*XLEN-1:3*XLEN];

   scsc_decode u_decode (
      .pc             (req_pc),
      .instr_word     (req_word),
      .library_end    (lib_end_ff),
      .ecall_word     (ecall_word_ff),
      .effective_word (dec_word),
      .dec            (dec_in)
   );

   scsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({sp_ff, pc_ff}),
      .rd_en   (accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = (req_tvalid) ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = (!rsp_valid_ff || rsp_tready) ? S_IDLE : S_EXEC;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            finish     = 1'b0;
         end
         S_EXEC: begin
            req_tready = 1'b0;
            finish     = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
            finish     = 1'b0;
         end
      endcase
   end

   assign accept      = req_tvalid && req_tready;
   assign ram_rd_addr = AW'(count_ff - CW'(2));
   assign ram_wr_addr = AW'(count_ff - CW'(1));

   always_comb begin
      top_pc      = (count_ff < CW'(2)) ? bottom_pc_ff : ram_rd_data[XLEN-1:0];
      top_sp      = (count_ff < CW'(2)) ? bottom_sp_ff : ram_rd_data[ENTRY_W-1:XLEN];
      ra_expect   = top_pc + RET_ADDR_STEP;
      status_in   = STAT_NONE;
      expected_in = '0;
      count_in    = count_ff;
      ram_wr_en   = 1'b0;
      push_bottom = 1'b0;
      if (dec_ff.is_pop) begin
         if (count_ff == '0) begin
            status_in = STAT_UNDERFLOW;
         end else if (ra_expect != ra_ff) begin
            status_in   = STAT_RA_MISMATCH;
            expected_in = ra_expect;
         end else if (top_sp != sp_ff) begin
            status_in   = STAT_SP_MISMATCH;
            expected_in = top_sp;
         end else begin
            status_in = STAT_POPPED;
            count_in  = count_ff - CW'(1);
         end
      end else if (dec_ff.is_call) begin
         if (count_ff >= CW'(STACK_DEPTH + 1)) begin
            status_in = STAT_OVERFLOW;
         end else begin
            status_in   = STAT_PUSHED;
            count_in    = count_ff + CW'(1);
            push_bottom = (count_ff == '0);
            ram_wr_en   = finish && (count_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= CW'(1);
         rsp_valid_ff  <= 1'b0;
         lib_end_ff    <= '0;
         ecall_word_ff <= ECALL_RESET;
         bottom_pc_ff  <= '0;
         bottom_sp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LIBRARY_END: lib_end_ff    <= csr_wdata;
               CSR_ECALL_WORD:  ecall_word_ff <= csr_wdata;
               CSR_START_PC:    bottom_pc_ff  <= csr_wdata;
               CSR_INITIAL_SP:  bottom_sp_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (finish) begin
            count_ff <= count_in;
            if (push_bottom) begin
               bottom_pc_ff <= pc_ff;
               bottom_sp_ff <= sp_ff;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pc_ff       <= req_pc;
         ra_ff       <= req_ra;
         sp_ff       <= req_sp;
         eff_word_ff <= dec_word;
         dec_ff      <= dec_in;
      end
      if (finish) begin
         rsp_status_ff   <= status_in;
         rsp_word_ff     <= eff_word_ff;
         rsp_expected_ff <= expected_in;
         rsp_depth_ff    <= DEPTH_OUT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, rsp_depth_ff, rsp_expected_ff,
                        rsp_word_ff, rsp_status_ff};

endmodule

// File: verif/shadow_call_stack_checker_test.sv
// Self-checking testbench for the shadow call stack checker: streamed instructions, predicted checks.
`timescale 1ns / 100ps

module shadow_call_stack_checker_test
   import scsc_pkg::*;
();

   localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [XLEN-1:0] sp;
      logic [XLEN-1:0] ra;
      logic [XLEN-1:0] word;
      logic [XLEN-1:0] pc;
   } instr_type;

   typedef struct packed {
      logic [DEPTH_OUT_W-1:0] depth;
      logic [XLEN-1:0]        expected;
      logic [XLEN-1:0]        word;
      status_type             status;
   } check_type;

   typedef struct packed {
      logic [STACK_DEPTH-1:0][XLEN-1:0] pcs;
      logic [STACK_DEPTH-1:0][XLEN-1:0] sps;
      logic [XLEN-1:0]                  bottom_pc;
      logic [XLEN-1:0]                  bottom_sp;
      logic [DEPTH_OUT_W-1:0]           count;
   } shadow_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_LIBRARY_END;
   logic [XLEN-1:0]       csr_wdata = '0;

   instr_type pending_instrs[$];
   check_type expected_checks[$];
   shadow_type dut_shadow;
   shadow_type plan_shadow;
   logic [XLEN-1:0] lib_end_cfg;
   logic [XLEN-1:0] ecall_cfg;
   int idle_pct = 0;
   int error_count = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   shadow_call_stack_checker #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void top_entry(input shadow_type s, output logic [XLEN-1:0] cpc,
                                     output logic [XLEN-1:0] csp);
      if (s.count <= 1) begin
         cpc = s.bottom_pc;
         csp = s.bottom_sp;
      end else begin
         cpc = s.pcs[s.count - 2];
         csp = s.sps[s.count - 2];
      end
   endfunction

   function automatic void shadow_step(inout shadow_type s, input instr_type it,
                                       output check_type r);
      logic [XLEN-1:0] w, cpc, csp;
      w = (it.pc < lib_end_cfg) ? ecall_cfg : it.word;
      r = '0;
      r.word = w;
      if (w == RET_WORD || w == ecall_cfg) begin
         if (s.count == 0) begin
            r.status = STAT_UNDERFLOW;
         end else begin
            top_entry(s, cpc, csp);
            if (cpc + RET_ADDR_STEP != it.ra) begin
               r.status = STAT_RA_MISMATCH;
               r.expected = cpc + RET_ADDR_STEP;
            end else if (csp != it.sp) begin
               r.status = STAT_SP_MISMATCH;
               r.expected = csp;
            end else begin
               r.status = STAT_POPPED;
               s.count = s.count - 1;
            end
         end
      end else if (w[11:7] == RA_REG && (w[6:0] == OPC_JAL || w[6:0] == OPC_JALR)) begin
         if (s.count >= STACK_DEPTH + 1) begin
            r.status = STAT_OVERFLOW;
         end else begin
            if (s.count == 0) begin
               s.bottom_pc = it.pc;
               s.bottom_sp = it.sp;
            end else begin
               s.pcs[s.count - 1] = it.pc;
               s.sps[s.count - 1] = it.sp;
            end
            s.count = s.count + 1;
            r.status = STAT_PUSHED;
         end
      end
      r.depth = s.count;
   endfunction

   function automatic logic [XLEN-1:0] pc_above_library();
      logic [63:0] span, pick;
      logic [XLEN-1:0] offset;
      span = 64'h1_0000_0000 - {32'h0, lib_end_cfg};
      pick = {$urandom, $urandom} % span;
      offset = pick[XLEN-1:0];
      return lib_end_cfg + offset;
   endfunction

   task automatic plan_item(input logic [XLEN-1:0] pc, word, ra, sp);
      instr_type it;
      check_type unused;
      it = '{sp: sp, ra: ra, word: word, pc: pc};
      shadow_step(plan_shadow, it, unused);
      pending_instrs = {pending_instrs, it};
   endtask

   // pop against the planned top entry, with optional corruption of ra and sp
   task automatic plan_pop(input logic [XLEN-1:0] pc, word, ra_flip, sp_flip);
      logic [XLEN-1:0] cpc, csp;
      top_entry(plan_shadow, cpc, csp);
      plan_item(pc, word, (cpc + RET_ADDR_STEP) ^ ra_flip, csp ^ sp_flip);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [XLEN-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LIBRARY_END: lib_end_cfg = val;
         CSR_ECALL_WORD:  ecall_cfg = val;
         CSR_START_PC: begin
            dut_shadow.bottom_pc = val;
            plan_shadow.bottom_pc = val;
         end
         CSR_INITIAL_SP: begin
            dut_shadow.bottom_sp = val;
            plan_shadow.bottom_sp = val;
         end
         default: ;
      endcase
   endtask

   task automatic configure(input logic [XLEN-1:0] lib_end, ecall, start_pc, start_sp);
      write_reg(CSR_LIBRARY_END, lib_end);
      write_reg(CSR_ECALL_WORD, ecall);
      write_reg(CSR_START_PC, start_pc);
      write_reg(CSR_INITIAL_SP, start_sp);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_instrs.size() != 0 || expected_checks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic plan_random(input int count, input int call_pct);
      logic [XLEN-1:0] w, flip;
      for (int i = 0; i < count; i++) begin
         flip = 32'h1 << $urandom_range(0, 31);
         if ($urandom_range(0, 99) < 12) begin
            plan_item($urandom, $urandom, $urandom, $urandom);
         end else if ($urandom_range(0, 99) < call_pct) begin
            w = $urandom;
            if ($urandom_range(0, 9) != 0) w[11:7] = RA_REG;
            w[6:0] = $urandom_range(0, 1) ? OPC_JAL : OPC_JALR;
            plan_item(pc_above_library(), w, $urandom, $urandom);
         end else begin
            case ($urandom_range(0, 9))
               0: plan_pop(pc_above_library(), RET_WORD, flip, '0);
               1: plan_pop(pc_above_library(), RET_WORD, '0, flip);
               2: begin
                  if (lib_end_cfg != 0)
                     plan_pop($urandom_range(0, lib_end_cfg - 1), $urandom, '0, '0);
                  else
                     plan_pop(pc_above_library(), RET_WORD, '0, '0);
               end
               3: plan_pop(pc_above_library(), ecall_cfg, '0, '0);
               default: plan_pop(pc_above_library(), RET_WORD, '0, '0);
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("shadow_call_stack_checker test failed");
         $finish;
      end
   end

   always @(posedge clock) begin : req_driver
      check_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            shadow_step(dut_shadow, pending_instrs[0], predicted);
            expected_checks = {expected_checks, predicted};
            void'(pending_instrs.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the transfer until taken
         end else if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_instrs.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_gap <= $urandom_range(0, 6);
            req_tvalid <= 1'b0;
         end else if (pending_instrs.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_instrs[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      check_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[RSP_FIELD_W-1:0];
            if (expected_checks.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected transfer: status %0d word %h expected %h depth %0d",
                           seen.status, seen.word, seen.expected, seen.depth);
            end else begin
               want = expected_checks.pop_front();
               if (seen.status !== want.status || seen.word !== want.word ||
                   seen.expected !== want.expected || seen.depth !== want.depth) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: want status %0d word %h expected %h depth %0d, %s",
                              want.status, want.word, want.expected, want.depth,
                              $sformatf("got status %0d word %h expected %h depth %0d",
                                        seen.status, seen.word, seen.expected, seen.depth));
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_gap <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      lib_end_cfg = '0;
      ecall_cfg = ECALL_RESET;
      dut_shadow = '0;
      dut_shadow.count = 1;
      plan_shadow = dut_shadow;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      configure(32'h0000_0100, ECALL_RESET, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
      plan_item(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      plan_item(32'h0000_1000, 32'h0000_00EF, 32'hFFFF_FFFF, 32'h0000_8000);
      plan_item(32'h0000_2000, 32'h0000_70E7, 32'h0000_0000, 32'h0000_7000);
      plan_item(32'h0000_3000, 32'h0000_02EF, 32'h0000_0000, 32'h0000_0000);
      plan_item(32'h0000_3004, 32'h0000_0067, 32'h0000_0000, 32'h0000_0000);
      plan_pop(32'h0000_4000, RET_WORD, 32'h8000_0000, 32'h0);
      plan_pop(32'h0000_4000, RET_WORD, 32'h0, 32'h0000_0001);
      plan_pop(32'h0000_4000, RET_WORD, 32'h0, 32'h0);
      plan_pop(32'h0000_5000, ECALL_RESET, 32'h0, 32'h0);
      // library pc pops the bottom entry; its return address wraps
      plan_pop(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
      plan_pop(32'h0000_0100, RET_WORD, 32'h0, 32'h0);
      plan_item(32'h0000_0100, 32'hFFFF_F0EF, 32'h0000_0000, 32'h1234_5678);
      plan_pop(32'h0000_00FF, 32'h0000_0000, 32'h0, 32'h0);
      plan_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      plan_item(32'h0000_0000, RET_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      plan_item(32'hFFFF_FFFF, 32'hFFFF_F0E7, 32'h5555_5555, 32'hAAAA_AAAA);
      wait_drained();

      idle_pct = 0;
      configure(32'h0000_0000, ECALL_RESET, 32'h0000_0000, 32'h0000_0000);
      plan_random(85, 50);
      wait_drained();

      idle_pct = 30;
      configure($urandom >> 4, RET_WORD, $urandom, $urandom);
      plan_random(85, 40);
      wait_drained();

      // deep nesting: drive the stack to full and beyond
      idle_pct = 15;
      configure(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      plan_random(100, 95);
      plan_random(40, 20);
      wait_drained();

      idle_pct = 25;
      configure(32'hFFFF_FFFF, 32'h0000_00EF, $urandom, $urandom);
      plan_random(85, 55);
      wait_drained();

      idle_pct = 0;
      configure(32'h0000_0400, 32'h0000_0000, $urandom, $urandom);
      plan_random(85, 50);
      wait_drained();

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_checks.size() == 0)
         $display("shadow_call_stack_checker test passed");
      else
         $display("shadow_call_stack_checker test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/scsc_pkg.sv
rtl/core/scsc_ram.sv
rtl/core/scsc_decode.sv
rtl/core/shadow_call_stack_checker.sv
verif/shadow_call_stack_checker_test.sv
